FILE: rtl/hhlf_pkg.sv
// Shared types, constants and byte tables for the HTTP header line forwarder.
package hhlf_pkg;

  localparam int LINE_BYTES_DEF  = 256;
  localparam int LENGTH_BITS_DEF = 40;
  localparam int QUEUE_DEPTH     = 4;

  // command fields sized for the largest line store
  localparam int CMD_ADDR_W = 9;
  localparam int CMD_LEN_W  = 10;

  localparam logic [7:0] CHR_CR    = 8'h0d;
  localparam logic [7:0] CHR_LF    = 8'h0a;
  localparam logic [7:0] CHR_SP    = 8'h20;
  localparam logic [7:0] CHR_H     = 8'h48;
  localparam logic [7:0] CHR_T     = 8'h54;
  localparam logic [7:0] CHR_C     = 8'h43;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;

  localparam logic [4:0] CL_PAT_LEN = 5'd16;
  localparam logic [4:0] CL_DONE    = 5'd17;
  localparam logic [4:0] TE_PAT_LEN = 5'd19;

  // injected header followed by the blank line; the last two bytes alone end a response
  localparam logic [4:0] TEXT_REQ_START  = 5'd0;
  localparam logic [4:0] TEXT_RESP_START = 5'd29;
  localparam logic [CMD_LEN_W-1:0] TEXT_REQ_LEN  = CMD_LEN_W'(31);
  localparam logic [CMD_LEN_W-1:0] TEXT_RESP_LEN = CMD_LEN_W'(2);

  localparam logic [8*31-1:0] INJECT_TEXT = "Transfer-Encoding: identity\r\n\r\n";
  localparam logic [8*16-1:0] CL_TEXT     = "Content-Length: ";
  localparam logic [8*19-1:0] TE_TEXT     = "Transfer-Encoding: ";

  localparam logic [1:0] ST_CONTINUE = 2'd0;
  localparam logic [1:0] ST_COMPLETE = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;
  localparam logic [1:0] ST_BAD_METH = 2'd3;

  localparam logic [2:0] METH_GET = 3'd0;

  typedef enum logic [1:0] {
    K_STATUS = 2'd0,
    K_MEM    = 2'd1,
    K_TEXT   = 2'd2,
    K_BYTE   = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic                  wr_en;
    logic [CMD_ADDR_W-1:0] wr_addr;
    logic [7:0]            wr_byte;
    logic [CMD_LEN_W-1:0]  len;
    logic [4:0]            start;
    logic [1:0]            status;
    logic                  in_body;
  } cmd_t;

  function automatic logic [7:0] inject_byte(input logic [4:0] idx);
    if (idx > 5'd30) return 8'h00;
    return INJECT_TEXT[8*(30-int'(idx)) +: 8];
  endfunction

  function automatic logic [7:0] cl_byte(input logic [3:0] idx);
    return CL_TEXT[8*(15-int'(idx)) +: 8];
  endfunction

  function automatic logic [7:0] te_byte(input logic [4:0] idx);
    if (idx > 5'd18) return 8'h00;
    return TE_TEXT[8*(18-int'(idx)) +: 8];
  endfunction

  // method names, first character in the lowest byte lane
  function automatic logic [63:0] meth_name(input logic [2:0] m);
    case (m)
      3'd0:    return 64'h0000_0000_0054_4547; // GET
      3'd1:    return 64'h0000_0000_5453_4f50; // POST
      3'd2:    return 64'h0000_0000_0054_5550; // PUT
      3'd3:    return 64'h0000_4554_454c_4544; // DELETE
      3'd4:    return 64'h0000_0000_4441_4548; // HEAD
      3'd5:    return 64'h0053_4e4f_4954_504f; // OPTIONS
      3'd6:    return 64'h0000_0045_4341_5254; // TRACE
      default: return 64'h0054_4345_4e4e_4f43; // CONNECT
    endcase
  endfunction

  function automatic logic [3:0] meth_len(input logic [2:0] m);
    case (m)
      3'd0:    return 4'd3;
      3'd1:    return 4'd4;
      3'd2:    return 4'd3;
      3'd3:    return 4'd6;
      3'd4:    return 4'd4;
      3'd5:    return 4'd7;
      3'd6:    return 4'd5;
      default: return 4'd7;
    endcase
  endfunction

endpackage

FILE: rtl/hhlf_in_if.sv
// Input byte channel.
interface hhlf_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;

  modport source (output valid, func, data_byte, input ready);
  modport sink   (input valid, func, data_byte, output ready);
endinterface

FILE: rtl/hhlf_out_if.sv
// Result word channel.
interface hhlf_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_data;
  logic [3:0]  out_count;
  logic        last;
  logic [1:0]  status;
  logic        in_body;

  modport source (output valid, out_data, out_count, last, status, in_body, input ready);
  modport sink   (input valid, out_data, out_count, last, status, in_body, output ready);
endinterface

FILE: rtl/hhlf_front.sv
// Front end: parses each byte, tracks header state and issues one command per byte.
module hhlf_front #(
  parameter int LINE_BYTES  = 256,
  parameter int LENGTH_BITS = 40
) (
  input  logic            clk,
  input  logic            rst_n,
  hhlf_in_if.sink         in_ch,
  output hhlf_pkg::cmd_t  cmd,
  output logic            cmd_push,
  input  logic            cmd_space
);
  import hhlf_pkg::*;

  localparam int AW = $clog2(LINE_BYTES);
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  logic [AW-1:0]          ll_r, ll_nxt;
  logic                   hdr_r, hdr_nxt;
  logic                   first_r, first_nxt;
  logic                   req_r, req_nxt;
  logic [2:0]             meth_r, meth_nxt;
  logic                   known_r, known_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic [4:0]             clp_r, clp_nxt;
  logic [LENGTH_BITS-1:0] dig_r, dig_nxt;
  logic [4:0]             tep_r, tep_nxt;
  logic                   tes_r, tes_nxt;
  logic                   halt_r, halt_nxt;
  logic                   prev_cr_r, prev_cr_nxt;
  logic [7:0]             head_r [8];
  logic [7:0]             hv [8];

  logic                   accept;
  logic [7:0]             b;
  logic [AW-1:0]          new_len;
  logic [LENGTH_BITS+3:0] dsum;
  logic [4:0]             clp_s, tep_s;
  logic [LENGTH_BITS-1:0] dig_s;
  logic                   tes_s;
  logic                   req_v, ok, found, mok;
  logic [2:0]             mfound;
  logic [63:0]            nm;
  logic [3:0]             nl;

  assign in_ch.ready = cmd_space;
  assign accept      = in_ch.valid & cmd_space;
  assign cmd_push    = accept;
  assign b           = in_ch.data_byte;
  assign new_len     = ll_r + AW'(1);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      hv[i] = (ll_r == AW'(i)) ? b : head_r[i];
    end
  end

  // pattern scanners for the current byte
  always_comb begin
    clp_s = clp_r;
    dig_s = dig_r;
    tep_s = tep_r;
    tes_s = tes_r;
    dsum  = {1'b0, dig_r, 3'b000} + {3'b000, dig_r, 1'b0}
          + {{(LENGTH_BITS){1'b0}}, b[3:0] - CHR_ZERO[3:0]};
    if (clp_r >= CL_PAT_LEN) begin
      if (clp_r == CL_PAT_LEN) begin
        if (b >= CHR_ZERO && b <= CHR_NINE) begin
          dig_s = (|dsum[LENGTH_BITS+3:LENGTH_BITS]) ? LEN_MAX : dsum[LENGTH_BITS-1:0];
        end else begin
          clp_s = CL_DONE;
        end
      end
    end else if (b == cl_byte(clp_r[3:0])) begin
      clp_s = clp_r + 5'd1;
    end else begin
      clp_s = (b == CHR_C) ? 5'd1 : 5'd0;
    end
    if (!tes_r) begin
      if (b == te_byte(tep_r)) begin
        tep_s = tep_r + 5'd1;
        if (tep_s >= TE_PAT_LEN) begin
          tes_s = 1'b1;
          tep_s = 5'd0;
        end
      end else begin
        tep_s = (b == CHR_T) ? 5'd1 : 5'd0;
      end
    end
  end

  // method search over the first eight bytes of the line
  always_comb begin
    found  = 1'b0;
    mfound = METH_GET;
    nm     = '0;
    nl     = '0;
    mok    = 1'b0;
    for (int m = 0; m < 8; m++) begin
      nm  = meth_name(3'(m));
      nl  = meth_len(3'(m));
      mok = 1'b1;
      for (int i = 0; i < 8; i++) begin
        if (4'(i) < nl) begin
          if (hv[i] != nm[8*i +: 8] || new_len <= AW'(i)) mok = 1'b0;
        end else if (4'(i) == nl) begin
          if (hv[i] != CHR_SP || new_len <= AW'(i)) mok = 1'b0;
        end
      end
      if (mok && !found) begin
        found  = 1'b1;
        mfound = 3'(m);
      end
    end
  end

  always_comb begin
    ll_nxt      = ll_r;
    hdr_nxt     = hdr_r;
    first_nxt   = first_r;
    req_nxt     = req_r;
    meth_nxt    = meth_r;
    known_nxt   = known_r;
    rem_nxt     = rem_r;
    clp_nxt     = clp_r;
    dig_nxt     = dig_r;
    tep_nxt     = tep_r;
    tes_nxt     = tes_r;
    halt_nxt    = halt_r;
    prev_cr_nxt = prev_cr_r;
    req_v       = req_r;
    ok          = 1'b1;

    cmd         = '0;
    cmd.kind    = K_STATUS;
    cmd.wr_addr = CMD_ADDR_W'(ll_r);
    cmd.wr_byte = b;
    cmd.status  = ST_CONTINUE;
    cmd.in_body = !hdr_r;

    if (in_ch.func) begin
      ll_nxt      = '0;
      hdr_nxt     = 1'b1;
      first_nxt   = 1'b1;
      req_nxt     = 1'b0;
      meth_nxt    = METH_GET;
      known_nxt   = 1'b0;
      rem_nxt     = '0;
      clp_nxt     = '0;
      dig_nxt     = '0;
      tep_nxt     = '0;
      tes_nxt     = 1'b0;
      halt_nxt    = 1'b0;
      prev_cr_nxt = 1'b0;
      cmd.in_body = 1'b0;
    end else if (halt_r) begin
      cmd.kind = K_STATUS;
    end else if (!hdr_r) begin
      if (known_r && rem_r == '0) begin
        halt_nxt   = 1'b1;
        cmd.status = ST_COMPLETE;
      end else begin
        cmd.kind = K_BYTE;
        cmd.len  = CMD_LEN_W'(1);
        if (known_r) begin
          rem_nxt = rem_r - LENGTH_BITS'(1);
          if (rem_nxt == '0) begin
            halt_nxt   = 1'b1;
            cmd.status = ST_COMPLETE;
          end
        end
      end
    end else if ({1'b0, ll_r} + (AW+1)'(2) >= (AW+1)'(LINE_BYTES)) begin
      halt_nxt   = 1'b1;
      cmd.status = ST_TOO_LONG;
    end else begin
      cmd.wr_en   = 1'b1;
      ll_nxt      = new_len;
      prev_cr_nxt = (b == CHR_CR);
      clp_nxt     = clp_s;
      dig_nxt     = dig_s;
      tep_nxt     = tep_s;
      tes_nxt     = tes_s;
      if (prev_cr_r && b == CHR_LF) begin
        // end of line: clear the scanners for the next one
        ll_nxt      = '0;
        prev_cr_nxt = 1'b0;
        clp_nxt     = '0;
        dig_nxt     = '0;
        tep_nxt     = '0;
        tes_nxt     = 1'b0;
        if (new_len == AW'(2)) begin
          hdr_nxt     = 1'b0;
          cmd.in_body = 1'b1;
          cmd.wr_en   = 1'b0;
          cmd.kind    = K_TEXT;
          cmd.start   = req_r ? TEXT_REQ_START : TEXT_RESP_START;
          cmd.len     = req_r ? TEXT_REQ_LEN : TEXT_RESP_LEN;
          if ((req_r && meth_r == METH_GET) || (known_r && rem_r == '0)) begin
            halt_nxt   = 1'b1;
            cmd.status = ST_COMPLETE;
          end
        end else begin
          if (first_r) begin
            first_nxt = 1'b0;
            known_nxt = 1'b0;
            if (hv[0] == CHR_H && hv[1] == CHR_T) begin
              req_v = 1'b0;
            end else begin
              req_v = 1'b1;
              if (found) meth_nxt = mfound;
              else ok = 1'b0;
            end
            req_nxt = req_v;
          end
          if (!ok) begin
            halt_nxt   = 1'b1;
            cmd.status = ST_BAD_METH;
          end else begin
            if (clp_s >= CL_PAT_LEN) begin
              known_nxt = 1'b1;
              rem_nxt   = dig_s;
            end
            if (!(req_v && tes_s)) begin
              cmd.kind = K_MEM;
              cmd.len  = CMD_LEN_W'(new_len);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ll_r      <= '0;
      hdr_r     <= 1'b1;
      first_r   <= 1'b1;
      req_r     <= 1'b0;
      meth_r    <= METH_GET;
      known_r   <= 1'b0;
      rem_r     <= '0;
      clp_r     <= '0;
      dig_r     <= '0;
      tep_r     <= '0;
      tes_r     <= 1'b0;
      halt_r    <= 1'b0;
      prev_cr_r <= 1'b0;
    end else if (accept) begin
      ll_r      <= ll_nxt;
      hdr_r     <= hdr_nxt;
      first_r   <= first_nxt;
      req_r     <= req_nxt;
      meth_r    <= meth_nxt;
      known_r   <= known_nxt;
      rem_r     <= rem_nxt;
      clp_r     <= clp_nxt;
      dig_r     <= dig_nxt;
      tep_r     <= tep_nxt;
      tes_r     <= tes_nxt;
      halt_r    <= halt_nxt;
      prev_cr_r <= prev_cr_nxt;
    end
  end

  // copy of the line's first bytes for the method check
  always_ff @(posedge clk) begin
    if (accept && cmd.wr_en) begin
      for (int i = 0; i < 8; i++) begin
        if (ll_r == AW'(i)) head_r[i] <= b;
      end
    end
  end

endmodule

FILE: rtl/hhlf_queue.sv
// Small command queue between front and back ends.
module hhlf_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  hhlf_pkg::cmd_t push_cmd,
  input  logic           push,
  output logic           space,
  output hhlf_pkg::cmd_t pop_cmd,
  output logic           avail,
  input  logic           pop
);
  import hhlf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t          slot_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;

  assign space   = (cnt_r != (PW+1)'(DEPTH));
  assign avail   = (cnt_r != '0);
  assign pop_cmd = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH-1)) ? '0 : wp_r + PW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(DEPTH-1)) ? '0 : rp_r + PW'(1);
    end
    if (push && !pop) cnt_nxt = cnt_r + (PW+1)'(1);
    else if (!push && pop) cnt_nxt = cnt_r - (PW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_cmd;
  end

endmodule

FILE: rtl/hhlf_back.sv
// Back end: holds the line store and packs forwarded bytes into result words.
module hhlf_back #(
  parameter int LINE_BYTES = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  hhlf_pkg::cmd_t cmd,
  input  logic           cmd_avail,
  output logic           cmd_pop,
  hhlf_out_if.source     out_ch
);
  import hhlf_pkg::*;

  localparam int AW = $clog2(LINE_BYTES);
  localparam int IW = (AW > 5) ? AW : 5;

  typedef enum logic {S_IDLE, S_STREAM} state_t;

  state_t               state_r;
  cmd_t                 cur_r;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic [CMD_LEN_W-1:0] remain_r;
  logic [63:0]          word_r, word_w;
  logic [3:0]           cnt_r;
  logic [7:0]           mem [LINE_BYTES];
  logic [7:0]           mem_q;
  logic [7:0]           src_byte;
  logic                 advance, emit;

  logic                 ov_r;
  logic [63:0]          od_r;
  logic [3:0]           oc_r;
  logic                 ol_r;
  logic [1:0]           os_r;
  logic                 ob_r;

  assign out_ch.valid     = ov_r;
  assign out_ch.out_data  = od_r;
  assign out_ch.out_count = oc_r;
  assign out_ch.last      = ol_r;
  assign out_ch.status    = os_r;
  assign out_ch.in_body   = ob_r;

  assign advance = !ov_r || out_ch.ready;
  assign cmd_pop = (state_r == S_IDLE) && cmd_avail;

  always_comb begin
    case (cur_r.kind)
      K_MEM:   src_byte = mem_q;
      K_TEXT:  src_byte = inject_byte(idx_r[4:0]);
      K_BYTE:  src_byte = cur_r.wr_byte;
      default: src_byte = 8'h00;
    endcase
    word_w = word_r | ({56'd0, src_byte} << {cnt_r[2:0], 3'b000});
    emit   = (state_r == S_STREAM) && advance
           && (remain_r == '0 || remain_r == CMD_LEN_W'(1) || cnt_r == 4'd7);
  end

  // read address runs one step ahead so mem_q always shows the byte at idx_r
  always_comb begin
    idx_nxt = idx_r;
    if (cmd_pop) begin
      idx_nxt = (cmd.kind == K_TEXT) ? IW'(cmd.start) : '0;
    end else if (state_r == S_STREAM && advance) begin
      idx_nxt = idx_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.wr_en) mem[cmd.wr_addr[AW-1:0]] <= cmd.wr_byte;
    mem_q <= mem[idx_nxt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      cnt_r   <= '0;
      word_r  <= '0;
    end else begin
      // load a new result or drop the one just taken
      if (emit) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (cmd_pop) begin
            state_r <= S_STREAM;
            cnt_r   <= '0;
            word_r  <= '0;
          end
        end
        S_STREAM: begin
          if (advance) begin
            if (remain_r == '0) begin
              // status-only result
              od_r    <= '0;
              oc_r    <= '0;
              ol_r    <= 1'b1;
              os_r    <= cur_r.status;
              ob_r    <= cur_r.in_body;
              state_r <= S_IDLE;
            end else if (emit) begin
              od_r   <= word_w;
              oc_r   <= cnt_r + 4'd1;
              ol_r   <= (remain_r == CMD_LEN_W'(1));
              os_r   <= (remain_r == CMD_LEN_W'(1)) ? cur_r.status : ST_CONTINUE;
              ob_r   <= cur_r.in_body;
              word_r <= '0;
              cnt_r  <= '0;
              if (remain_r == CMD_LEN_W'(1)) state_r <= S_IDLE;
            end else begin
              word_r <= word_w;
              cnt_r  <= cnt_r + 4'd1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd_pop) begin
      cur_r    <= cmd;
      remain_r <= cmd.len;
    end else if (state_r == S_STREAM && advance && remain_r != '0) begin
      remain_r <= remain_r - CMD_LEN_W'(1);
    end
  end

endmodule

FILE: rtl/http_header_line_forwarder_unit.sv
// Top level of the HTTP header line forwarder.
//
//   channel  | dir | payload                                   | transfer
//   in_ch    | in  | func, data_byte                           | valid & ready
//   out_ch   | out | out_data, out_count, last, status, in_body | valid & ready
//
// A byte passes through the combinational front end into a four-entry queue.
// The back end takes one command at a time; for a forwarded line end it streams
// every byte of the stored line through the store's read port, packed into words.
// Reset is synchronous; no clearing pass. A stalled result holds the back end
// while the front end keeps filling the queue until it is full.
module http_header_line_forwarder_unit #(
  parameter int LINE_BYTES  = hhlf_pkg::LINE_BYTES_DEF,
  parameter int LENGTH_BITS = hhlf_pkg::LENGTH_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  hhlf_in_if.sink    in_ch,
  hhlf_out_if.source out_ch
);
  import hhlf_pkg::*;

  cmd_t f_cmd, q_cmd;
  logic f_push, q_space, q_avail, q_pop;

  hhlf_front #(
    .LINE_BYTES  (LINE_BYTES),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd       (f_cmd),
    .cmd_push  (f_push),
    .cmd_space (q_space)
  );

  hhlf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cmd (f_cmd),
    .push     (f_push),
    .space    (q_space),
    .pop_cmd  (q_cmd),
    .avail    (q_avail),
    .pop      (q_pop)
  );

  hhlf_back #(
    .LINE_BYTES (LINE_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (q_cmd),
    .cmd_avail (q_avail),
    .cmd_pop   (q_pop),
    .out_ch    (out_ch)
  );

endmodule

FILE: test/hhlf_tb_pkg.sv
// Stimulus codes shared by the header line forwarder testbench.
package hhlf_tb_pkg;
  typedef enum logic {
    FN_BYTE  = 1'b0,
    FN_START = 1'b1
  } hhlf_func_e;
endpackage

FILE: test/testbench.sv
// Self-checking testbench for the HTTP header line forwarder: predicted result words vs DUT.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hhlf_pkg::*;
  import hhlf_tb_pkg::*;

  localparam int LB = LINE_BYTES_DEF;
  localparam int LW = LENGTH_BITS_DEF;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
    logic [1:0]  status;
    logic        in_body;
  } word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  hhlf_in_if  in_ch();
  hhlf_out_if out_ch();

  http_header_line_forwarder_unit u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [7:0]    ls_mem [LB];
  int            ls_len;
  bit            hdr_ph, first_pend, is_req, halt, len_known, te_seen;
  logic [2:0]    meth;
  logic [LW-1:0] remain, digits;
  int            cl_pos, te_pos;

  word_t exp_q[$];
  word_t step_q[$];
  logic [63:0] acc;
  int acc_n;
  int errors = 0;
  int idle_cycles = 0;
  bit long_hold = 1'b0;

  localparam string CL_S = "Content-Length: ";
  localparam string TE_S = "Transfer-Encoding: ";
  localparam string INJ_S = "Transfer-Encoding: identity\r\n";
  string meth_names[8] = '{"GET", "POST", "PUT", "DELETE", "HEAD", "OPTIONS", "TRACE",
                           "CONNECT"};

  task automatic report_mismatch(input string what);
    errors++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  function automatic void model_clear();
    ls_len = 0; hdr_ph = 1; first_pend = 1; is_req = 0; meth = METH_GET;
    len_known = 0; remain = '0; digits = '0; cl_pos = 0; te_pos = 0;
    te_seen = 0; halt = 0;
  endfunction

  function automatic void flush_word();
    word_t w;
    if (acc_n == 0) return;
    w = '{data: acc, count: 4'(acc_n), last: 1'b0, status: ST_CONTINUE, in_body: 1'b0};
    step_q.push_back(w);
    acc = '0; acc_n = 0;
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    acc[8*acc_n +: 8] = b;
    acc_n++;
    if (acc_n == 8) flush_word();
  endfunction

  function automatic void close_step(input logic [1:0] st);
    word_t w;
    flush_word();
    if (step_q.size() == 0) step_q.push_back('0);
    foreach (step_q[k]) begin
      w = step_q[k];
      w.in_body = !hdr_ph;
      if (k == step_q.size() - 1) begin
        w.last = 1'b1; w.status = st;
      end
      exp_q.push_back(w);
    end
    step_q.delete();
  endfunction

  function automatic void scan_char(input logic [7:0] b);
    logic [LW-1:0] d, maxv;
    maxv = '1;
    if (cl_pos >= 16) begin
      if (cl_pos == 16) begin
        if (b >= CHR_ZERO && b <= CHR_NINE) begin
          d = LW'(b - CHR_ZERO);
          if (digits > (maxv - d) / 10) digits = maxv;
          else digits = digits * 10 + d;
        end else cl_pos = 17;
      end
    end else if (b == CL_S[cl_pos]) cl_pos++;
    else cl_pos = (b == CL_S[0]) ? 1 : 0;
    if (!te_seen) begin
      if (b == TE_S[te_pos]) begin
        te_pos++;
        if (te_pos >= 19) begin
          te_seen = 1; te_pos = 0;
        end
      end else te_pos = (b == TE_S[0]) ? 1 : 0;
    end
  endfunction

  function automatic bit method_found();
    int i;
    bit ok;
    for (int m = 0; m < 8; m++) begin
      ok = 1;
      for (i = 0; i < meth_names[m].len(); i++)
        if (i >= ls_len || ls_mem[i] != meth_names[m][i]) begin
          ok = 0;
          break;
        end
      if (ok && i < ls_len && ls_mem[i] == CHR_SP) begin
        meth = 3'(m);
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic void predict_item(input hhlf_func_e fn, input logic [7:0] b);
    acc = '0; acc_n = 0; step_q.delete();
    if (fn == FN_START) begin
      model_clear(); close_step(ST_CONTINUE); return;
    end
    if (halt) begin
      close_step(ST_CONTINUE); return;
    end
    if (!hdr_ph) begin
      if (len_known && remain == 0) begin
        halt = 1; close_step(ST_COMPLETE); return;
      end
      put_byte(b);
      if (len_known) begin
        remain = remain - 1'b1;
        if (remain == 0) begin
          halt = 1; close_step(ST_COMPLETE); return;
        end
      end
      close_step(ST_CONTINUE); return;
    end
    if (ls_len + 2 >= LB) begin
      halt = 1; close_step(ST_TOO_LONG); return;
    end
    ls_mem[ls_len] = b;
    ls_len++;
    scan_char(b);
    if (ls_len < 2 || ls_mem[ls_len-2] != CHR_CR || ls_mem[ls_len-1] != CHR_LF) begin
      close_step(ST_CONTINUE); return;
    end
    if (ls_len == 2) begin
      hdr_ph = 0;
      if (is_req) for (int i = 0; i < INJ_S.len(); i++) put_byte(INJ_S[i]);
      put_byte(CHR_CR); put_byte(CHR_LF);
      ls_len = 0; cl_pos = 0; digits = '0; te_pos = 0; te_seen = 0;
      if ((is_req && meth == METH_GET) || (len_known && remain == 0)) begin
        halt = 1; close_step(ST_COMPLETE); return;
      end
      close_step(ST_CONTINUE); return;
    end
    if (first_pend) begin
      first_pend = 0; len_known = 0;
      if (ls_mem[0] == CHR_H && ls_mem[1] == CHR_T) is_req = 0;
      else begin
        is_req = 1;
        if (!method_found()) begin
          halt = 1; close_step(ST_BAD_METH); return;
        end
      end
    end
    if (cl_pos >= 16) begin
      len_known = 1; remain = digits;
    end
    if (!(is_req && te_seen)) for (int i = 0; i < ls_len; i++) put_byte(ls_mem[i]);
    ls_len = 0; cl_pos = 0; digits = '0; te_pos = 0; te_seen = 0;
    close_step(ST_CONTINUE);
  endfunction

  // sender: random bursts and gaps
  int burst_left = 0;

  task automatic send_item(input hhlf_func_e fn, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.func <= fn;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(fn, b);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(FN_BYTE, s[i]);
  endtask

  task automatic send_random_bytes(input int n);
    repeat (n) send_item(FN_BYTE, 8'($urandom));
  endtask

  task automatic wait_drained();
    while (exp_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic test_get_request();
    send_item(FN_START, 8'hff);
    send_text("GET /a HTTP/1.1\r\nHost: x\r\nTransfer-Encoding: chunked\r\n\r\n");
    send_random_bytes(2);
  endtask

  task automatic test_response_with_length();
    send_item(FN_START, 8'h00);
    send_text("HTTP/1.1 200 OK\r\nContent-Length: 3\r\n\r\n");
    send_item(FN_BYTE, 8'h00);
    send_item(FN_BYTE, 8'hff);
    send_random_bytes(3);
  endtask

  task automatic test_bad_method_and_long_line();
    send_item(FN_START, 8'h00);
    send_text("GETX /\r\n");
    send_item(FN_BYTE, 8'h41);
    send_item(FN_START, 8'h00);
    send_text("HTTP ");
    send_random_bytes(LB);
  endtask

  task automatic test_pressure();
    long_hold = 1'b1;
    send_item(FN_START, 8'h00);
    send_text("POST / HTTP/1.1\r\nContent-Length: 99999999999999\r\nAbc: 1234567890\r\n\r\n");
    long_hold = 1'b0;
    send_random_bytes(10);
  endtask

  // well-formed messages with random content, plus some noise
  task automatic test_random_messages();
    int sent;
    string s;
    sent = 0;
    while (sent < 110) begin
      send_item(FN_START, 8'($urandom));
      case ($urandom_range(0, 5))
        0: s = "HTTP/1.0 204\r\n";
        1: s = {meth_names[$urandom_range(0, 7)], " /p\r\n"};
        2: s = "XYZ\r\n";
        default: s = {meth_names[$urandom_range(1, 7)], " /q\r\n"};
      endcase
      send_text(s);
      sent += s.len();
      if ($urandom_range(0, 1)) begin
        s = $sformatf("Content-Length: %0d\r\n", $urandom_range(0, 6));
        send_text(s);
        sent += s.len();
      end
      if ($urandom_range(0, 3) == 0) begin
        send_text("Transfer-Encoding: gzip\r\n");
        sent += 25;
      end
      if ($urandom_range(0, 4) == 0) begin
        send_random_bytes(4);
        sent += 4;
      end
      send_text("\r\n");
      send_random_bytes($urandom_range(1, 8));
      sent += 10;
    end
  endtask

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int hold;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        for (hold = 0; hold < 300; hold++) @(negedge clk);
        long_hold = 1'b0;
      end
      out_ch.ready <= ($urandom_range(0, 15) < 11) || (($time % 4000) < 800);
    end
  end

  // result checker
  always @(posedge clk) begin
    word_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{data: out_ch.out_data, count: out_ch.out_count, last: out_ch.last,
              status: out_ch.status, in_body: out_ch.in_body};
      if (exp_q.size() == 0) report_mismatch("result with nothing expected");
      else begin
        want = exp_q.pop_front();
        if (got.data !== want.data)
          report_mismatch($sformatf("data %h want %h", got.data, want.data));
        if (got.count !== want.count)
          report_mismatch($sformatf("count %0d want %0d", got.count, want.count));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %b want %b", got.last, want.last));
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d want %0d", got.status, want.status));
        if (got.in_body !== want.in_body)
          report_mismatch($sformatf("in_body %b want %b", got.in_body, want.in_body));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = FN_BYTE;
    in_ch.data_byte = 8'h00;
    model_clear();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_get_request();
    test_response_with_length();
    test_bad_method_and_long_line();
    test_pressure();
    test_random_messages();
    in_ch.valid <= 1'b0;
    wait_drained();
    if (errors == 0 && exp_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
